[hdl/utf8_stream_decoder_unit_assert.svh]
// Assertion macros for the decoder's top-level RTL file.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define UTF8SD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define UTF8SD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/utf8sd_pkg.sv]
// Package of types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

    // Width of the byte position counters and of the error offset field
    localparam int OFFSET_BITS = 16;
    localparam int CP_BITS     = 21;
    localparam int BYTE_BITS   = 8;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Output tdata: code point then error offset, padded to whole bytes
    localparam int OUT_DATA_BITS = ((CP_BITS + OFFSET_BITS + 7) / 8) * 8;

    // Byte-order mark as decoded code point
    localparam logic [CP_BITS-1:0] BOM_CP = 21'h00FEFF;

    typedef enum logic [1:0] {
        KIND_CP  = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [CP_BITS-1:0]     acc;
        logic [1:0]             rem;
        logic [2:0]             width;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] lead;
        logic                   discarding;
    } t_state;

    // One result item, with a flag for whether the byte gave one
    typedef struct packed {
        logic                   valid;
        t_kind                  kind;
        logic [CP_BITS-1:0]     cp;
        logic [OFFSET_BITS-1:0] off;
        logic                   fin;
    } t_result;

endpackage

[hdl/utf8sd_step.sv]
// Combinational decode of one byte against the current decoder state.
module utf8sd_step
    import utf8sd_pkg::*;
(
    input  t_state                i_state,
    input  logic [BYTE_BITS-1:0]  i_byte,
    input  logic                  i_last,
    output t_state                o_state,
    output t_result               o_result
);

    always_comb begin
        t_state                 s;
        t_result                res;
        logic [2:0]             w;
        logic [CP_BITS-1:0]     v;
        logic                   bad;
        logic                   fail_now;
        logic [OFFSET_BITS-1:0] fail_off;

        s        = i_state;
        res      = '0;
        res.kind = KIND_CP;
        w        = '0;
        v        = '0;
        bad      = 1'b0;
        fail_now = 1'b0;
        fail_off = '0;

        if (!s.discarding) begin
            if (s.rem == 2'd0) begin
                // Lead byte: width and payload bits
                case (i_byte) inside
                    8'b0???????: begin
                        w = 3'd1;
                        v = CP_BITS'(i_byte[6:0]);
                    end
                    8'b110?????: begin
                        w = 3'd2;
                        v = CP_BITS'(i_byte[4:0]);
                    end
                    8'b1110????: begin
                        w = 3'd3;
                        v = CP_BITS'(i_byte[3:0]);
                    end
                    8'b11110???: begin
                        w = 3'd4;
                        v = CP_BITS'(i_byte[2:0]);
                    end
                    default: bad = 1'b1;
                endcase
                if (bad) begin
                    fail_now = 1'b1;
                    fail_off = s.pos;
                end else begin
                    s.acc   = v;
                    s.width = w;
                    s.rem   = 2'(w - 3'd1);
                    s.lead  = s.pos;
                end
            end else begin
                // Continuation byte: six more bits
                if (i_byte[7:6] != 2'b10) begin
                    fail_now = 1'b1;
                    fail_off = s.lead;
                end else begin
                    s.acc = {s.acc[CP_BITS-7:0], i_byte[5:0]};
                    s.rem = s.rem - 2'd1;
                end
            end

            if (!fail_now) begin
                if (s.rem == 2'd0) begin
                    // Sequence complete; a leading byte-order mark is dropped
                    if ((s.lead == '0) && (s.width == 3'd3) && (s.acc == BOM_CP)) begin
                        if (i_last) begin
                            res.valid = 1'b1;
                            res.kind  = KIND_END;
                            res.fin   = 1'b1;
                        end
                    end else begin
                        res.valid = 1'b1;
                        res.kind  = KIND_CP;
                        res.cp    = s.acc;
                        res.fin   = i_last;
                    end
                    s.acc   = '0;
                    s.width = '0;
                end else if (i_last) begin
                    // String ends inside a sequence
                    fail_now = 1'b1;
                    fail_off = s.lead;
                end
            end

            if (fail_now) begin
                res.valid = 1'b1;
                res.kind  = KIND_ERR;
                res.cp    = '0;
                res.off   = fail_off;
                res.fin   = 1'b1;
                s.acc     = '0;
                s.rem     = '0;
                s.width   = '0;
                if (!i_last) begin
                    s.discarding = 1'b1;
                end
            end
        end

        // Position moves on once per byte; the last byte clears the string
        if (i_last) begin
            s = '0;
        end else if (s.pos != OFFSET_MAX) begin
            s.pos = s.pos + 1'b1;
        end

        o_state  = s;
        o_result = res;
    end

endmodule

[hdl/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder: input stage, state and result register.
//
// Usage:
//   Slave side (i_s_*) takes one byte of text per item; tlast flags the last
//   byte of a string. Master side (o_m_*) gives zero or one result per byte:
//   tuser holds the kind (code point, end with nothing to give, error),
//   tdata the code point and the error offset, tlast the final result of
//   the string. An error is always final; later bytes of that string up to
//   its last byte are dropped.
//   Path: a byte is held in the input register, then decoded combinationally
//   into the result register.
//   Throughput: one byte per cycle while the result register has room,
//   set by the single state update between the input and result registers.
//   A stalled receiver holds the result; one more byte is still taken into
//   the input register, and bytes that give no result keep flowing.
//   Reset (synchronous, active low) clears the decoder state and both
//   register stages; the next byte is taken as the start of a new string.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave side
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [BYTE_BITS-1:0]     i_s_tdata,   // [7:0] in_byte
    input  logic                     i_s_tlast,   // end_of_text
    // master side
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // code_point, error_offset, zero pad
    output logic [1:0]               o_m_tuser,   // kind
    output logic                     o_m_tlast    // final_result
);

    `include "utf8_stream_decoder_unit_assert.svh"

    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_in_last;
    t_state               r_state;
    t_state               n_state;
    t_result              n_result;
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [CP_BITS-1:0]   r_out_cp;
    logic [OFFSET_BITS-1:0] r_out_off;
    logic                 r_out_fin;
    logic                 s_accept;
    logic                 advance;

    // Decode of the buffered byte
    utf8sd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Buffered byte moves on when its result has room, or it gives none
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready || !n_result.valid);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Input stage and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_out_kind <= n_result.kind;
            r_out_cp   <= n_result.cp;
            r_out_off  <= n_result.off;
            r_out_fin  <= n_result.fin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_out_off, r_out_cp});
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_fin;

    // Checks
    `UTF8SD_ASSERT_IMP(a_err_final, r_out_valid && (r_out_kind == KIND_ERR), r_out_fin,
        "error result not marked final")
    `UTF8SD_ASSERT_IMP(a_cp_zero, r_out_valid && (r_out_kind != KIND_CP), r_out_cp == '0,
        "code point set on a result that is not a code point")
    `UTF8SD_ASSERT_IMP(a_off_zero, r_out_valid && (r_out_kind != KIND_ERR), r_out_off == '0,
        "error offset set on a result that is not an error")
    `UTF8SD_ASSERT_NXT(a_last_clears, advance && r_in_last, r_state == '0,
        "decoder state not cleared after the last byte of a string")
    `UTF8SD_ASSERT_IMP(a_discard_idle, r_state.discarding, r_state.rem == 2'd0,
        "sequence still open while discarding")

endmodule

[tb/utf8sd_stream_checker.sv]
`timescale 1ns / 1ps
// Checker for the UTF-8 stream decoder: predicts results from accepted bytes and compares them.
module utf8sd_stream_checker
    import utf8sd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // byte side, as seen on the bus
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [BYTE_BITS-1:0]     i_s_tdata,   // [7:0] in_byte
    input  logic                     i_s_tlast,   // end_of_text
    // result side, as seen on the bus
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [OUT_DATA_BITS-1:0] i_m_tdata,   // code_point, error_offset, zero pad
    input  logic [1:0]               i_m_tuser,   // kind
    input  logic                     i_m_tlast,   // final_result
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        t_kind                  kind;
        logic [CP_BITS-1:0]     cp;
        logic [OFFSET_BITS-1:0] off;
        logic                   fin;
    } t_decoded;

    // results still owed by the block, oldest first
    t_decoded decoded_q[$];

    int mismatches = 0;
    int waiting    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // decoder state as predicted
    logic [CP_BITS-1:0]     acc       = '0;
    logic [1:0]             remaining = '0;
    logic [2:0]             seq_width = '0;
    logic [OFFSET_BITS-1:0] byte_pos  = '0;
    logic [OFFSET_BITS-1:0] lead_pos  = '0;
    logic                   dropping  = 1'b0;

    task automatic clear_string();
        acc       = '0;
        remaining = '0;
        seq_width = '0;
        byte_pos  = '0;
        lead_pos  = '0;
        dropping  = 1'b0;
    endtask

    // end of string resets everything, otherwise the position moves on and saturates
    task automatic next_pos(input logic last);
        if (last) begin
            clear_string();
        end else if (byte_pos != OFFSET_MAX) begin
            byte_pos = byte_pos + 1'b1;
        end
    endtask

    task automatic decode_byte(input logic [BYTE_BITS-1:0] b, input logic last);
        logic                   err;
        logic [OFFSET_BITS-1:0] err_off;
        err     = 1'b0;
        err_off = '0;
        // rest of a failed string is dropped
        if (dropping) begin
            next_pos(last);
            return;
        end
        if (remaining == 2'd0) begin
            // lead byte: width and payload bits
            case (b) inside
                8'b0???????: begin
                    seq_width = 3'd1;
                    acc       = CP_BITS'(b[6:0]);
                end
                8'b110?????: begin
                    seq_width = 3'd2;
                    acc       = CP_BITS'(b[4:0]);
                end
                8'b1110????: begin
                    seq_width = 3'd3;
                    acc       = CP_BITS'(b[3:0]);
                end
                8'b11110???: begin
                    seq_width = 3'd4;
                    acc       = CP_BITS'(b[2:0]);
                end
                default: begin
                    err     = 1'b1;
                    err_off = byte_pos;
                end
            endcase
            if (!err) begin
                remaining = 2'(seq_width - 3'd1);
                lead_pos  = byte_pos;
            end
        end else if (b[7:6] != 2'b10) begin
            err     = 1'b1;
            err_off = lead_pos;
        end else begin
            acc       = {acc[CP_BITS-7:0], b[5:0]};
            remaining = remaining - 2'd1;
        end
        // string ends with the sequence unfinished
        if (!err && remaining != 2'd0 && last) begin
            err     = 1'b1;
            err_off = lead_pos;
        end
        if (err) begin
            decoded_q.push_back('{kind: KIND_ERR, cp: '0, off: err_off, fin: 1'b1});
            acc       = '0;
            remaining = '0;
            seq_width = '0;
            if (!last) begin
                dropping = 1'b1;
            end
            next_pos(last);
        end else if (remaining == 2'd0) begin
            // byte-order mark at the string start gives no code point
            if (lead_pos == '0 && seq_width == 3'd3 && acc == BOM_CP) begin
                if (last) begin
                    decoded_q.push_back('{kind: KIND_END, cp: '0, off: '0, fin: 1'b1});
                end
            end else begin
                decoded_q.push_back('{kind: KIND_CP, cp: acc, off: '0, fin: last});
            end
            acc       = '0;
            seq_width = '0;
            next_pos(last);
        end else begin
            next_pos(1'b0);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // compare results first, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            clear_string();
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with none expected", i_m_tdata[31:0], '0);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tuser != want.kind) begin
                        report_mismatch("kind", 32'(i_m_tuser), 32'(want.kind));
                    end
                    if (i_m_tdata[CP_BITS-1:0] != want.cp) begin
                        report_mismatch("code point", 32'(i_m_tdata[CP_BITS-1:0]),
                                        32'(want.cp));
                    end
                    if (i_m_tdata[CP_BITS +: OFFSET_BITS] != want.off) begin
                        report_mismatch("error offset",
                                        32'(i_m_tdata[CP_BITS +: OFFSET_BITS]),
                                        32'(want.off));
                    end
                    if (i_m_tlast != want.fin) begin
                        report_mismatch("final flag", 32'(i_m_tlast), 32'(want.fin));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast);
            end
        end
        waiting = decoded_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module tb;
    import utf8sd_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int STALL_LIMIT  = 2000;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [BYTE_BITS-1:0]     i_s_tdata  = '0;  // [7:0] in_byte
    logic                     i_s_tlast  = 1'b0; // end_of_text
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;         // code_point, error_offset, zero pad
    logic [1:0]               o_m_tuser;         // kind
    logic                     o_m_tlast;         // final_result

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic calm        = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    utf8_stream_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    utf8sd_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls now and then, never during the calm stretch
    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 6);
    end

    // watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one string, last byte flagged; called and returned at a falling edge
    task automatic send_text(input logic [7:0] bytes[$]);
        foreach (bytes[k]) begin
            while (!calm && $urandom_range(99) < 6) begin
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= bytes[k];
            i_s_tlast  <= (k == bytes.size() - 1);
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    initial begin
        logic [7:0]  txt[$];
        logic [31:0] rnd;
        int          sent_items;
        int          string_idx;
        int          mode;
        int          w;
        int          n_chars;
        int          pick;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, lead bytes of every width, mark handling and each error path
        txt = '{8'h00};
        send_text(txt);
        txt = '{8'hEF, 8'hBB, 8'hBF};                      // mark alone: end result
        send_text(txt);
        txt = '{8'hEF, 8'hBB, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F,
                8'hEF, 8'hBB, 8'hBF};                      // mark later is a code point
        send_text(txt);
        txt = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};               // widest value
        send_text(txt);
        txt = '{8'hFF, 8'h41};                             // invalid lead, rest dropped
        send_text(txt);
        txt = '{8'h80};                                    // stray continuation
        send_text(txt);
        txt = '{8'hC3, 8'h41};                             // broken sequence on last byte
        send_text(txt);
        txt = '{8'hDF};                                    // short ending
        send_text(txt);

        // random strings: mostly well formed, some noise, some broken
        sent_items = 0;
        string_idx = 0;
        while (sent_items < RANDOM_ITEMS) begin
            calm = (string_idx >= 40 && string_idx < 70);
            if (string_idx == 25) begin
                // hold off until the block has delivered everything
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            txt.delete();
            mode = $urandom_range(99);
            if (mode < 12) begin
                n_chars = $urandom_range(1, 8);
                repeat (n_chars) txt.push_back(8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 15) begin
                    txt = '{8'hEF, 8'hBB, 8'hBF};
                end
                n_chars = $urandom_range(1, 6);
                repeat (n_chars) begin
                    w   = $urandom_range(1, 4);
                    rnd = $urandom();
                    case (w)
                        1: txt.push_back({1'b0, rnd[6:0]});
                        2: txt.push_back({3'b110, rnd[4:0]});
                        3: txt.push_back({4'b1110, rnd[3:0]});
                        default: txt.push_back({5'b11110, rnd[2:0]});
                    endcase
                    repeat (w - 1) begin
                        rnd = $urandom();
                        txt.push_back({2'b10, rnd[5:0]});
                    end
                end
                if (mode >= 80) begin
                    pick = $urandom_range(txt.size() - 1);
                    rnd  = $urandom();
                    case ($urandom_range(2))
                        0: txt[pick] = rnd[7:0];
                        1: txt.push_back({3'b110, rnd[4:0]});
                        default: txt[pick] = {5'b11111, rnd[2:0]};
                    endcase
                end
            end
            send_text(txt);
            sent_items = sent_items + txt.size();
            string_idx = string_idx + 1;
        end
        calm = 1'b0;

        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8sd_step.sv
hdl/utf8_stream_decoder_unit.sv
tb/utf8sd_stream_checker.sv
tb/tb.sv
